// ===== hdl/ffba_pkg.sv =====
// Package for the first-fit block allocator.
// Holds store geometry, word layouts, controller states and the command and status structs.
// No dependencies.
package ffba_pkg;

  localparam int CAPACITY_WORDS = 64;
  localparam int ADDR_W         = $clog2(CAPACITY_WORDS);
  localparam int POS_W          = ADDR_W + 1;
  localparam int HDR_W          = 9;
  localparam int NEED_W         = HDR_W + 1;
  localparam int REQ_W          = 8;

  localparam logic [HDR_W-1:0]  TOTAL_BYTES = HDR_W'(CAPACITY_WORDS * 4);
  localparam logic [NEED_W-1:0] HEADER_BYTES = NEED_W'(4);
  localparam logic [NEED_W-1:0] ALIGN_ADD    = NEED_W'(3);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_FREE_EVAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic step;
    logic grant_wr;
    logic split_wr;
    logic free_wr;
    logic res_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic stop;
    logic split;
  } status_t;

endpackage

// ===== hdl/ffba_ctrl.sv =====
// Controller state machine of the first-fit block allocator.
// Sequences the header walk, the writes and the result handshake; uses ffba_pkg.
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_op_i ? ST_FREE_EVAL : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.fit) begin
          state_d = status_i.split ? ST_SPLIT : ST_RESP;
        end else if (status_i.stop) begin
          state_d = ST_RESP;
        end
      end
      ST_SPLIT:     state_d = ST_RESP;
      ST_FREE_EVAL: state_d = ST_RESP;
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load     = in_valid_i;
        cmd_o.rd_first = in_valid_i;
      end
      ST_WALK: begin
        if (status_i.fit) begin
          cmd_o.grant_wr = 1'b1;
        end else if (status_i.stop) begin
          cmd_o.res_fail = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_SPLIT:     cmd_o.split_wr = 1'b1;
      ST_FREE_EVAL: cmd_o.free_wr  = 1'b1;
      ST_RESP: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ffba_datapath.sv =====
// Datapath of the first-fit block allocator.
// Holds the header store with its valid bits, the walk position, the fit logic and the result registers; uses ffba_pkg.
module ffba_datapath
  import ffba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_op_i,
  input  logic [REQ_W-1:0]      in_request_bytes_i,
  input  logic [ADDR_W-1:0]     in_free_index_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  out_granted_o,
  output logic [ADDR_W-1:0]     out_header_index_o,
  output logic [HDR_W-1:0]      out_block_bytes_o
);

  logic [HDR_W-1:0]  mem [CAPACITY_WORDS];
  logic [CAPACITY_WORDS-1:0] valid_q;

  logic [NEED_W-1:0] need_q;
  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] pos_q;
  logic [HDR_W-1:0]  rdata_q;
  logic              rvld_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [HDR_W-1:0]  rem_q;
  logic [ADDR_W-1:0] split_addr_q;

  logic              res_granted_q;
  logic [ADDR_W-1:0] res_idx_q;
  logic [HDR_W-1:0]  res_bytes_q;
  logic              out_granted_q;
  logic [ADDR_W-1:0] out_idx_q;
  logic [HDR_W-1:0]  out_bytes_q;

  logic [NEED_W-1:0] req_round;
  logic [NEED_W-1:0] need_d;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [HDR_W-1:0]  hdr;
  logic [HDR_W-1:0]  size_raw;
  logic [HDR_W-1:0]  left;
  logic [HDR_W-1:0]  size;
  logic [POS_W-1:0]  nxt_pos;
  logic [POS_W:0]    split_pos;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;

  assign req_round = NEED_W'(in_request_bytes_i) + ALIGN_ADD;
  assign need_d    = {req_round[NEED_W-1:2], 2'b00} + HEADER_BYTES;

  assign rd_en   = cmd_i.rd_first || cmd_i.step;
  assign rd_addr = cmd_i.step ? nxt_pos[ADDR_W-1:0]
                              : (in_op_i ? in_free_index_i : '0);

  assign hdr      = rvld_q ? rdata_q : ((raddr_q == '0) ? TOTAL_BYTES : '0);
  assign size_raw = {hdr[HDR_W-1:2], 2'b00};
  assign left     = TOTAL_BYTES - HDR_W'({pos_q, 2'b00});
  assign size     = (size_raw > left) ? left : size_raw;
  assign nxt_pos  = POS_W'(pos_q) + POS_W'(size[HDR_W-1:2]);
  assign split_pos = (POS_W+1)'(pos_q) + (POS_W+1)'(need_q[NEED_W-1:2]);

  assign status_o.fit   = !hdr[0] && (NEED_W'(size) >= need_q);
  assign status_o.stop  = (size == '0) || (nxt_pos >= POS_W'(CAPACITY_WORDS));
  assign status_o.split = (NEED_W'(size) > need_q)
                          && (split_pos < (POS_W+1)'(CAPACITY_WORDS));

  always_comb begin
    wr_en   = cmd_i.grant_wr || cmd_i.split_wr || cmd_i.free_wr;
    wr_addr = pos_q;
    wr_data = {need_q[HDR_W-1:1], 1'b1};
    priority if (cmd_i.split_wr) begin
      wr_addr = split_addr_q;
      wr_data = rem_q;
    end else if (cmd_i.free_wr) begin
      wr_addr = idx_q;
      wr_data = {hdr[HDR_W-1:1], 1'b0};
    end else begin
      wr_addr = pos_q;
      wr_data = {need_q[HDR_W-1:1], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rvld_q  <= valid_q[rd_addr];
      raddr_q <= rd_addr;
    end
    if (cmd_i.load) begin
      need_q <= need_d;
      idx_q  <= in_free_index_i;
    end
    if (cmd_i.rd_first) begin
      pos_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= nxt_pos[ADDR_W-1:0];
    end
    if (cmd_i.grant_wr) begin
      rem_q         <= size - need_q[HDR_W-1:0];
      split_addr_q  <= split_pos[ADDR_W-1:0];
      res_granted_q <= 1'b1;
      res_idx_q     <= pos_q;
      res_bytes_q   <= need_q[HDR_W-1:0];
    end else if (cmd_i.res_fail) begin
      res_granted_q <= 1'b0;
      res_idx_q     <= '0;
      res_bytes_q   <= '0;
    end else if (cmd_i.free_wr) begin
      res_granted_q <= hdr[0];
      res_idx_q     <= idx_q;
      res_bytes_q   <= hdr[0] ? size_raw : '0;
    end
    if (cmd_i.out_load) begin
      out_granted_q <= res_granted_q;
      out_idx_q     <= res_idx_q;
      out_bytes_q   <= res_bytes_q;
    end
  end

  assign out_granted_o      = out_granted_q;
  assign out_header_index_o = out_idx_q;
  assign out_block_bytes_o  = out_bytes_q;

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// First-fit block allocator over an implicit list of block headers in a 64-word store.
// An allocate request walks the headers one per cycle from word 0 and takes the first free
// block that is large enough, splitting off the remainder; a free request clears the
// allocated bit of the named header. One request is worked on at a time. An allocate loads the
// request, visits N headers in the walk state (N from 1 to 64) and writes any remainder header
// in the split state; a free reads the named header and writes it back. The walk is set by the
// single read port of the header store, which delivers one header per cycle. A finished result
// waits in an output register, so the next request can be taken while it is unread, but its
// result is loaded only once the previous word has left. Reset needs no clearing pass.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: request_bytes[7:0], free_index[13:8], zero fill[15:14].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: op.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: granted[0], header_index[6:1], block_bytes[15:7].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t              cmd;
  status_t           status;
  logic              granted;
  logic [ADDR_W-1:0] header_index;
  logic [HDR_W-1:0]  block_bytes;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ffba_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_op_i            (s_axis_tuser),
    .in_request_bytes_i (s_axis_tdata[REQ_W-1:0]),
    .in_free_index_i    (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_granted_o      (granted),
    .out_header_index_o (header_index),
    .out_block_bytes_o  (block_bytes)
  );

  assign m_axis_tdata = {block_bytes, header_index, granted};

endmodule

// ===== hdl/ffba_checker.sv =====
// Port-level assertions for the first-fit block allocator, bound to the top level.
// Uses ffba_pkg.
module ffba_assertions
  import ffba_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_fail_zero_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[15:7] == '0))
    else $error("Refused word carries a nonzero block size.");

  a_grant_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0])
      |-> (m_axis_tdata[8:7] == 2'b00) && (m_axis_tdata[15:7] != '0))
    else $error("Granted word carries a block size that is zero or not word aligned.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("Input taken again before the previous request finished.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output word changed while stalled.");

endmodule

bind first_fit_block_allocator ffba_assertions u_ffba_assertions (.*);

// ===== tb/ffba_tb_pkg.sv =====
// Shared types for the first-fit allocator testbench: request codes and the reply layout.
// Depends on ffba_pkg for the store geometry.
package ffba_tb_pkg;
  import ffba_pkg::*;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [HDR_W-1:0]  block_bytes;
    logic [ADDR_W-1:0] header_index;
    logic              granted;
  } reply_t;

endpackage

// ===== tb/ffba_checker.sv =====
// Checker for the first-fit allocator: keeps its own header store, works out the reply of
// each accepted request word and compares every reply word with the oldest one waiting.
// Depends on ffba_pkg and ffba_tb_pkg.
module ffba_checker
  import ffba_pkg::*;
  import ffba_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    error_count_o,
  output int                    pending_o
);

  logic [HDR_W-1:0] header_mem [CAPACITY_WORDS];
  reply_t           reply_q[$];
  int               errors;

  task automatic apply_request(input op_e op, input logic [REQ_W-1:0] req,
                               input logic [ADDR_W-1:0] idx, output reply_t rep);
    int  need;
    int  pos;
    int  size;
    int  left;
    int  hw;
    bit  done;
    rep  = '0;
    if (op == OP_ALLOC) begin
      need = ((int'(req) + 3) & ~3) + 4;
      pos  = 0;
      done = 1'b0;
      while (!done && pos < CAPACITY_WORDS) begin
        hw   = int'(header_mem[pos]);
        size = hw & ~3;
        left = CAPACITY_WORDS * 4 - pos * 4;
        if (size > left) size = left;
        if (size == 0) begin
          done = 1'b1;
        end else if ((hw & 1) == 0 && size >= need) begin
          header_mem[pos] = HDR_W'(need | 1);
          if (size > need && pos + need / 4 < CAPACITY_WORDS)
            header_mem[pos + need / 4] = HDR_W'(size - need);
          rep.granted      = 1'b1;
          rep.header_index = ADDR_W'(pos);
          rep.block_bytes  = HDR_W'(need);
          done = 1'b1;
        end else begin
          pos += size / 4;
        end
      end
    end else begin
      rep.header_index = idx;
      if (header_mem[idx][0]) begin
        header_mem[idx][0] = 1'b0;
        rep.granted     = 1'b1;
        rep.block_bytes = header_mem[idx] & ~HDR_W'(3);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY_WORDS; i++) header_mem[i] = '0;
      header_mem[0] = TOTAL_BYTES;
      reply_q.delete();
      errors = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata);
        if (reply_q.size() == 0) begin
          $error("reply word 0x%04h arrived with no request waiting", m_axis_tdata);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            errors++;
          end
          if (got.header_index !== want.header_index) begin
            $error("header_index: expected %0d, actual %0d",
                   want.header_index, got.header_index);
            errors++;
          end
          if (got.block_bytes !== want.block_bytes) begin
            $error("block_bytes: expected %0d, actual %0d",
                   want.block_bytes, got.block_bytes);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(op_e'(s_axis_tuser), s_axis_tdata[REQ_W-1:0],
                      s_axis_tdata[REQ_W+ADDR_W-1:REQ_W], want);
        reply_q.push_back(want);
      end
    end
    error_count_o <= errors;
    pending_o     <= reply_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the first-fit allocator testbench: clock, reset, request stimulus and verdict.
// Depends on ffba_pkg, ffba_tb_pkg, ffba_checker and first_fit_block_allocator.
module tb;
  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    error_count;
  int                    pending;

  bit                    calm = 1'b0;
  int                    stall_left = 0;
  logic [ADDR_W-1:0]     held_headers[$];

  first_fit_block_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ffba_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Granted headers are kept so that most free requests name a live block.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready && m_axis_tdata[0]) begin
      held_headers.push_back(m_axis_tdata[ADDR_W:1]);
      if (held_headers.size() > 48) void'(held_headers.pop_front());
    end
  end

  task automatic send_request(input op_e op, input int req, input int idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, ADDR_W'(idx), REQ_W'(req)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic alloc(input int req);
    send_request(OP_ALLOC, req, $urandom_range(0, CAPACITY_WORDS - 1));
  endtask

  task automatic release_block(input int idx);
    send_request(OP_FREE, $urandom_range(0, 255), idx);
  endtask

  initial begin
    int r;
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    alloc(0);
    alloc(1);
    alloc(3);
    alloc(4);
    alloc(255);
    release_block(0);
    release_block(0);
    release_block(CAPACITY_WORDS - 1);
    alloc(0);
    alloc(200);
    alloc(20);
    alloc(0);
    release_block(58);
    alloc(16);
    alloc(0);
    alloc(0);
    release_block(30);
    release_block(7);
    alloc(0);
    alloc(252);
    release_block(1);
    release_block(5);

    for (int n = 0; n < 600; n++) begin
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = $urandom_range(0, 99);
        if (k < 80) alloc($urandom_range(0, 32));
        else if (k < 95) alloc($urandom_range(33, 100));
        else alloc($urandom_range(101, 255));
      end else if (r < 90 && held_headers.size() > 0) begin
        k = $urandom_range(0, held_headers.size() - 1);
        release_block(held_headers[k]);
        held_headers.delete(k);
      end else begin
        release_block($urandom_range(0, CAPACITY_WORDS - 1));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
